@@ hw/rtl/gcqd_pkg.sv @@
package gcqd_pkg;

	localparam int LINEAR_FRACTION_BITS = 16;
	localparam int LIN_W       = LINEAR_FRACTION_BITS + 1;
	localparam int SUM_W       = LINEAR_FRACTION_BITS + 3;
	localparam int BYTE_W      = 8;
	localparam int LANES       = 4;
	localparam int QUAD        = 4;
	localparam int CODES       = 1 << BYTE_W;
	localparam int SRCH_STAGES = BYTE_W;
	localparam int LATENCY     = 2 + SRCH_STAGES;
	localparam int FIFO_DEPTH  = 16;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
	localparam int PIX_W       = LANES * BYTE_W;
	localparam int BIG_W       = 256;

	typedef logic [BIG_W-1:0] big_t;
	typedef logic [CODES-1:0][LIN_W-1:0] lin_tab_t;
	typedef logic [QUAD-1:0][BYTE_W-1:0] quad_t;
	typedef logic [LANES-1:0][BYTE_W-1:0] level_t;

	typedef struct packed {
		logic accept;
		logic push;
	} ctl_t;

	// x^5 * 255^11
	function automatic big_t scaled_fifth(input big_t x);
		big_t r;
		r = big_t'(1);
		for (int i = 0; i < 11; i++) begin
			r = r * big_t'(255);
		end
		for (int i = 0; i < 5; i++) begin
			r = r * x;
		end
		return r;
	endfunction

	// v^11 << s
	function automatic big_t shifted_eleventh(input big_t v, input int s);
		big_t r;
		r = big_t'(1);
		for (int i = 0; i < 11; i++) begin
			r = r * v;
		end
		return r << s;
	endfunction

	function automatic int decode_entry(input int v);
		big_t rhs;
		big_t lhs;
		int lo;
		int hi;
		int mid;
		lo  = 0;
		hi  = (1 << LINEAR_FRACTION_BITS) + 1;
		rhs = shifted_eleventh(big_t'(v), 5 * LINEAR_FRACTION_BITS + 5);
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			lhs = scaled_fifth(big_t'(2 * mid - 1));
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic int threshold_entry(input int k);
		big_t rhs;
		big_t lhs;
		int lo;
		int hi;
		int mid;
		lo  = 0;
		hi  = 1 << LINEAR_FRACTION_BITS;
		rhs = shifted_eleventh(big_t'(k), 5 * LINEAR_FRACTION_BITS);
		if (k == 0) begin
			return 0;
		end
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			lhs = scaled_fifth(big_t'(mid));
			if (lhs >= rhs) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		return hi;
	endfunction

	function automatic lin_tab_t build_lin_tab();
		lin_tab_t t;
		for (int v = 0; v < CODES; v++) begin
			t[v] = LIN_W'(decode_entry(v));
		end
		return t;
	endfunction

	function automatic lin_tab_t build_thr_tab();
		lin_tab_t t;
		for (int k = 0; k < CODES; k++) begin
			t[k] = LIN_W'(threshold_entry(k));
		end
		return t;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();
	localparam lin_tab_t THR_TAB = build_thr_tab();

endpackage

@@ hw/rtl/gcqd_lane.sv @@
module gcqd_lane (
	input  logic                          clk,
	input  gcqd_pkg::quad_t               sample,
	output logic [gcqd_pkg::BYTE_W-1:0]   level
);

	logic [gcqd_pkg::LIN_W-1:0] lin_s1 [gcqd_pkg::QUAD];
	logic [gcqd_pkg::SUM_W-1:0] sum;
	logic [gcqd_pkg::LIN_W-1:0] avg_s2;
	logic [gcqd_pkg::BYTE_W-1:0] srch_key_s3 [gcqd_pkg::SRCH_STAGES];
	logic [gcqd_pkg::LIN_W-1:0] srch_avg_s3 [gcqd_pkg::SRCH_STAGES-1];

	always_ff @(posedge clk) begin
		for (int p = 0; p < gcqd_pkg::QUAD; p++) begin
			lin_s1[p] <= gcqd_pkg::LIN_TAB[sample[p]];
		end
	end

	assign sum = gcqd_pkg::SUM_W'(lin_s1[0]) + gcqd_pkg::SUM_W'(lin_s1[1])
		+ gcqd_pkg::SUM_W'(lin_s1[2]) + gcqd_pkg::SUM_W'(lin_s1[3]);

	always_ff @(posedge clk) begin
		avg_s2 <= sum[gcqd_pkg::SUM_W-1:2];
	end

	// binary search over the thresholds, one key bit per stage, msb first
	for (genvar j = 0; j < gcqd_pkg::SRCH_STAGES; j++) begin : g_srch
		logic [gcqd_pkg::LIN_W-1:0]  avg_in;
		logic [gcqd_pkg::BYTE_W-1:0] key_in;
		logic [gcqd_pkg::BYTE_W-1:0] probe;

		if (j == 0) begin : g_first
			assign avg_in = avg_s2;
			assign key_in = '0;
		end else begin : g_next
			assign avg_in = srch_avg_s3[j-1];
			assign key_in = srch_key_s3[j-1];
		end

		assign probe = key_in | gcqd_pkg::BYTE_W'(1 << (gcqd_pkg::SRCH_STAGES - 1 - j));

		always_ff @(posedge clk) begin
			srch_key_s3[j] <= (gcqd_pkg::THR_TAB[probe] <= avg_in) ? probe : key_in;
		end

		if (j < gcqd_pkg::SRCH_STAGES - 1) begin : g_hold
			always_ff @(posedge clk) begin
				srch_avg_s3[j] <= avg_in;
			end
		end
	end

	assign level = srch_key_s3[gcqd_pkg::SRCH_STAGES-1];

endmodule

@@ hw/rtl/gcqd_merge.sv @@
module gcqd_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gcqd_pkg::ctl_t               ctl,
	input  gcqd_pkg::level_t             level,
	input  logic                         out_ready,
	output logic                         in_ready,
	output logic                         out_valid,
	output logic [gcqd_pkg::PIX_W-1:0]   blended_pixel
);

	logic [gcqd_pkg::PIX_W-1:0] mem_q [gcqd_pkg::FIFO_DEPTH];
	logic [gcqd_pkg::PTR_W-1:0] wr_ptr_q;
	logic [gcqd_pkg::PTR_W-1:0] rd_ptr_q;
	logic [gcqd_pkg::CNT_W-1:0] cnt_q;
	logic [gcqd_pkg::CNT_W-1:0] credit_q;
	logic                       pop;

	assign pop           = out_valid & out_ready;
	assign out_valid     = cnt_q != '0;
	assign in_ready      = credit_q < gcqd_pkg::CNT_W'(gcqd_pkg::FIFO_DEPTH);
	assign blended_pixel = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			// count every transfer in until its result leaves the buffer
			cnt_q    <= cnt_q + gcqd_pkg::CNT_W'(ctl.push) - gcqd_pkg::CNT_W'(pop);
			credit_q <= credit_q + gcqd_pkg::CNT_W'(ctl.accept) - gcqd_pkg::CNT_W'(pop);
		end
	end

`ifndef SYNTH
	a_cnt_in_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= credit_q)
		else $error("buffer holds more results than transfers in flight");

	a_credit_max: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= gcqd_pkg::CNT_W'(gcqd_pkg::FIFO_DEPTH))
		else $error("credit count beyond buffer depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (cnt_q < gcqd_pkg::CNT_W'(gcqd_pkg::FIFO_DEPTH) || pop))
		else $error("push into full buffer");
`endif

endmodule

@@ hw/rtl/gamma_correct_quad_downsample.sv @@
// Gamma-correct 2x2 box filter: one quad of RGBA8 pixels in, one averaged RGBA8 pixel
// out, one quad per clock sustained while results are taken. Four identical lanes, one
// per byte channel, each decode to linear light by table lookup, sum and halve twice,
// then re-encode by an eight-stage binary search over the threshold table; results
// appear in order. A 16-entry output buffer with credit counting keeps intake running
// while results wait; in_ready drops only when sixteen quads are in flight or
// buffered.
module gamma_correct_quad_downsample (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gcqd_pkg::PIX_W-1:0]  pixel_top_left,
	input  logic [gcqd_pkg::PIX_W-1:0]  pixel_top_right,
	input  logic [gcqd_pkg::PIX_W-1:0]  pixel_bottom_left,
	input  logic [gcqd_pkg::PIX_W-1:0]  pixel_bottom_right,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gcqd_pkg::PIX_W-1:0]  blended_pixel
);

	logic [gcqd_pkg::LATENCY-1:0] vld_q;
	gcqd_pkg::level_t             level;
	gcqd_pkg::ctl_t               ctl;

	assign ctl.accept = in_valid & in_ready;
	assign ctl.push   = vld_q[gcqd_pkg::LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[gcqd_pkg::LATENCY-2:0], ctl.accept};
		end
	end

	for (genvar ch = 0; ch < gcqd_pkg::LANES; ch++) begin : g_lane
		gcqd_pkg::quad_t sample;

		assign sample = {pixel_bottom_right[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W],
		                 pixel_bottom_left[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W],
		                 pixel_top_right[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W],
		                 pixel_top_left[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W]};

		gcqd_lane u_lane (
			.clk    (clk),
			.sample (sample),
			.level  (level[ch])
		);
	end

	gcqd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.level         (level),
		.out_ready     (out_ready),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.blended_pixel (blended_pixel)
	);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int FRAC_BITS   = gcqd_pkg::LINEAR_FRACTION_BITS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_QUADS = 650;

	typedef logic [gcqd_pkg::PIX_W-1:0] pix_t;
	typedef logic [255:0]     wide_t;

	class quad_blend_board;
		int   linear_of[gcqd_pkg::CODES];
		int   floor_of[gcqd_pkg::CODES];
		pix_t blend_q[$];
		int   errors;

		function new();
			errors = 0;
			for (int v = 0; v < gcqd_pkg::CODES; v++) begin
				linear_of[v] = linear_code(v);
				floor_of[v]  = threshold_code(v);
			end
		endfunction

		function wide_t ipow(int unsigned b, int e);
			wide_t r;
			r = wide_t'(1);
			for (int i = 0; i < e; i++) begin
				r = r * wide_t'(b);
			end
			return r;
		endfunction

		// round(2^F * (v/255)^2.2): largest m with (2m-1)^5 * 255^11 <= v^11 * 2^(5F+5)
		function int linear_code(int v);
			wide_t scale;
			wide_t gamma_side;
			int    m;
			scale      = ipow(255, 11);
			gamma_side = ipow(v, 11) << (5 * FRAC_BITS + 5);
			m = int'($floor((2.0 ** FRAC_BITS) * ((v / 255.0) ** 2.2) + 0.5));
			if (m < 0) begin
				m = 0;
			end
			while (m > 0 && ipow(2 * m - 1, 5) * scale > gamma_side) begin
				m--;
			end
			while (ipow(2 * m + 1, 5) * scale <= gamma_side) begin
				m++;
			end
			return m;
		endfunction

		// ceil(2^F * (k/255)^2.2): smallest m with m^5 * 255^11 >= k^11 * 2^(5F)
		function int threshold_code(int k);
			wide_t scale;
			wide_t gamma_side;
			int    m;
			if (k == 0) begin
				return 0;
			end
			scale      = ipow(255, 11);
			gamma_side = ipow(k, 11) << (5 * FRAC_BITS);
			m = int'($ceil((2.0 ** FRAC_BITS) * ((k / 255.0) ** 2.2)));
			if (m < 1) begin
				m = 1;
			end
			while (m > 1 && ipow(m - 1, 5) * scale >= gamma_side) begin
				m--;
			end
			while (ipow(m, 5) * scale < gamma_side) begin
				m++;
			end
			return m;
		endfunction

		function int reencode(int avg);
			for (int k = gcqd_pkg::CODES - 1; k > 0; k--) begin
				if (floor_of[k] <= avg) begin
					return k;
				end
			end
			return 0;
		endfunction

		function pix_t blend(pix_t tl, pix_t tr, pix_t bl, pix_t br);
			pix_t r;
			int   acc;
			for (int ch = 0; ch < gcqd_pkg::LANES; ch++) begin
				acc = linear_of[tl[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W]]
				    + linear_of[tr[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W]]
				    + linear_of[bl[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W]]
				    + linear_of[br[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W]];
				r[ch*gcqd_pkg::BYTE_W +: gcqd_pkg::BYTE_W] =
					gcqd_pkg::BYTE_W'(reencode(acc >> 2));
			end
			return r;
		endfunction

		function void note_quad(pix_t tl, pix_t tr, pix_t bl, pix_t br);
			blend_q.push_back(blend(tl, tr, bl, br));
		endfunction

		function void check_pixel(pix_t got);
			pix_t want;
			if (blend_q.size() == 0) begin
				$error("blended_pixel: transfer with no quad pending, actual %h", got);
				errors++;
			end else begin
				want = blend_q.pop_front();
				if (want !== got) begin
					$error("blended_pixel mismatch: expected %h actual %h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return blend_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pix_t pixel_top_left;
	pix_t pixel_top_right;
	pix_t pixel_bottom_left;
	pix_t pixel_bottom_right;
	logic out_valid;
	logic out_ready;
	pix_t blended_pixel;

	quad_blend_board board;
	int  cycle_count = 0;
	bit  in_burst = 1'b0;

	gamma_correct_quad_downsample dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pixel_top_left    (pixel_top_left),
		.pixel_top_right   (pixel_top_right),
		.pixel_bottom_left (pixel_bottom_left),
		.pixel_bottom_right(pixel_bottom_right),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.blended_pixel     (blended_pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_pixel(blended_pixel);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] extreme_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h7F;
			3: return 8'h80;
			4: return 8'hFE;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic pix_t extreme_pixel();
		return {extreme_byte(), extreme_byte(), extreme_byte(), extreme_byte()};
	endfunction

	task automatic send_quad(input pix_t tl, input pix_t tr, input pix_t bl, input pix_t br);
		int gap;
		gap = in_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid           <= 1'b1;
		pixel_top_left     <= tl;
		pixel_top_right    <= tr;
		pixel_bottom_left  <= bl;
		pixel_bottom_right <= br;
		do @(posedge clk); while (!in_ready);
		board.note_quad(tl, tr, bl, br);
	endtask

	task automatic send_uniform(input pix_t p);
		send_quad(p, p, p, p);
	endtask

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat (80) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		pix_t base;
		int   shape;
		board              = new();
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		pixel_top_left     = '0;
		pixel_top_right    = '0;
		pixel_bottom_left  = '0;
		pixel_bottom_right = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_uniform(32'h0000_0000);
		send_uniform(32'hFFFF_FFFF);
		send_uniform(32'h8080_8080);
		send_uniform(32'h01FE_7F40);
		send_uniform(32'h0102_0304);
		send_quad(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
		send_quad(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_quad(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_quad(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_quad(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_quad(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_quad(32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
		send_quad(32'h0101_0101, 32'h0, 32'h0101_0101, 32'h0101_0101);
		send_quad(32'h0101_0101, 32'hFEFE_FEFE, 32'h0101_0101, 32'hFEFE_FEFE);
		send_quad(32'hAA55_AA55, 32'h55AA_55AA, 32'hAA55_AA55, 32'h55AA_55AA);
		send_quad(32'hFEFE_FEFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_quad(32'h7F7F_7F7F, 32'h8080_8080, 32'h7F7F_7F7F, 32'h8080_8080);

		for (int n = 0; n < RANDOM_QUADS; n++) begin
			if (n % 40 == 0) begin
				in_burst = ($urandom_range(0, 3) == 0);
			end
			shape = $urandom_range(0, 3);
			base  = $urandom;
			case (shape)
				0: send_quad($urandom, $urandom, $urandom, $urandom);
				1: send_uniform(base);
				2: send_quad(base ^ ($urandom & 32'h0303_0303), base ^ ($urandom & 32'h0303_0303),
				             base ^ ($urandom & 32'h0303_0303), base ^ ($urandom & 32'h0303_0303));
				default: send_quad(extreme_pixel(), extreme_pixel(), extreme_pixel(),
				                   extreme_pixel());
			endcase
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (gcqd_pkg::LATENCY + 8) @(posedge clk);
		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/gcqd_pkg.sv
hw/rtl/gcqd_lane.sv
hw/rtl/gcqd_merge.sv
hw/rtl/gamma_correct_quad_downsample.sv
dv/tb.sv
